@@ src/assert_macros.svh @@
// -----------------------------------------------------------------------------
// assert_macros
// Assertion helpers for the checker file.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ src/bba_pkg.sv @@
// -----------------------------------------------------------------------------
// bba_pkg
// Shared types, codes and sizing helpers of the bitmap block allocator.
// -----------------------------------------------------------------------------
package bba_pkg;

	localparam int DEF_MAX_BLOCKS = 4096;
	localparam int DEF_WORD_BITS  = 32;

	localparam int OP_W  = 2;
	localparam int IDX_W = 12;
	localparam int ST_W  = 2;
	localparam int CFG_W = 13;

	localparam int CFG_RESET  = 4096;
	localparam int FIFO_DEPTH = 2;

	localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
	localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY = 2'd2;
	// spare code, has no effect
	localparam logic [OP_W-1:0] OP_RSVD  = 2'd3;

	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
	localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [IDX_W-1:0] block_index;
	} req_t;

	typedef struct packed {
		logic [ST_W-1:0]  status;
		logic [IDX_W-1:0] granted_index;
		logic             occupied;
	} rsp_t;

	// width of the effective block count: holds the register and MAX_BLOCKS
	function automatic int cnt_w(int max_blocks);
		int w;
		w = $clog2(max_blocks + 1);
		return (w > CFG_W) ? w : CFG_W;
	endfunction

endpackage

@@ src/bitmap_block_allocator.sv @@
// -----------------------------------------------------------------------------
// bitmap_block_allocator
// First-fit block allocator over an occupancy bitmap of MAX_BLOCKS bits held
// in a RAM of ceil(MAX_BLOCKS / WORD_BITS) words. After reset a clearing pass
// writes every word to zero, one word per cycle (128 words at the defaults);
// full stays high until it is done. Requests pass a two-stage front (range
// check, index to word and bit) and a short queue to the back, which owns the
// RAM port. A free or query reads its map word; a free then writes it back
// with the bit cleared. An allocate reads one map word per cycle from word 0
// up to the word holding the first free block, or until the block count is
// covered; this RAM scan sets the rate. The back takes the next request
// only when idle and once the last result is popped. The front keeps taking
// requests while the back works or a result waits, until the front is full.
// -----------------------------------------------------------------------------
module bitmap_block_allocator import bba_pkg::*; #(
	parameter int MAX_BLOCKS = DEF_MAX_BLOCKS,
	parameter int WORD_BITS  = DEF_WORD_BITS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  req_t             req,
	output logic             empty,
	input  logic             pop,
	output rsp_t             rsp,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CFG_W-1:0] cfg_data
);

	localparam int CW        = cnt_w(MAX_BLOCKS);
	localparam int MAP_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
	localparam int ADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int BIT_W     = $clog2(WORD_BITS);
	localparam int ENT_W     = OP_W + 1 + ADDR_W + BIT_W;
	localparam int CNT_RST   = (CFG_RESET > MAX_BLOCKS) ? MAX_BLOCKS : CFG_RESET;

	logic [CW-1:0]    count_q;
	logic             fe_full, fe_push;
	logic             q_push, q_full, q_valid, q_empty, q_pop;
	logic [ENT_W-1:0] q_din, q_dout;
	logic             clearing;

	assign cfg_ready = 1'b1;

	// effective count saturates at MAX_BLOCKS
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CW'(CNT_RST);
		end else if (cfg_valid && cfg_ready) begin
			count_q <= (CW'(cfg_data) > CW'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS) : CW'(cfg_data);
		end
	end

	assign full    = fe_full || clearing;
	assign fe_push = push && !clearing;
	assign q_valid = !q_empty;

	bba_front #(
		.MAX_BLOCKS (MAX_BLOCKS),
		.WORD_BITS  (WORD_BITS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fe_push),
		.full   (fe_full),
		.req    (req),
		.count  (count_q),
		.q_push (q_push),
		.q_full (q_full),
		.q_din  (q_din)
	);

	bba_queue #(
		.WIDTH (ENT_W),
		.DEPTH (FIFO_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.full   (q_full),
		.din    (q_din),
		.pop    (q_pop),
		.empty  (q_empty),
		.dout   (q_dout)
	);

	bba_back #(
		.MAX_BLOCKS (MAX_BLOCKS),
		.WORD_BITS  (WORD_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.count    (count_q),
		.q_valid  (q_valid),
		.q_dout   (q_dout),
		.q_pop    (q_pop),
		.clearing (clearing),
		.empty    (empty),
		.pop      (pop),
		.rsp      (rsp)
	);

endmodule

@@ src/bba_ram.sv @@
// -----------------------------------------------------------------------------
// bba_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// -----------------------------------------------------------------------------
module bba_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ src/bba_front.sv @@
// -----------------------------------------------------------------------------
// bba_front
// Takes requests, checks the index against the block count and splits it into
// map word and bit position before handing the request to the queue.
// -----------------------------------------------------------------------------
module bba_front import bba_pkg::*; #(
	parameter int MAX_BLOCKS = DEF_MAX_BLOCKS,
	parameter int WORD_BITS  = DEF_WORD_BITS,
	localparam int CW        = cnt_w(MAX_BLOCKS),
	localparam int MAP_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS,
	localparam int ADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1,
	localparam int BIT_W     = $clog2(WORD_BITS),
	localparam int ENT_W     = OP_W + 1 + ADDR_W + BIT_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  req_t             req,
	input  logic [CW-1:0]    count,
	output logic             q_push,
	input  logic             q_full,
	output logic [ENT_W-1:0] q_din
);

	// index / WORD_BITS as a multiply by a rounded-up reciprocal, exact for IDX_W bits
	localparam int SH = IDX_W + $clog2(WORD_BITS);
	localparam int RW = SH + 1;
	localparam int PW = IDX_W + RW;
	localparam logic [RW-1:0] RECIP = RW'(((64'(1) << SH) + WORD_BITS - 1) / WORD_BITS);

	logic             v_s1, v_s2;
	logic [OP_W-1:0]  op_s1, op_s2;
	logic             rng_s1, rng_s2;
	logic [IDX_W-1:0] idx_s1, idx_s2;
	logic [IDX_W-1:0] word_s2;

	logic             s1_ready, s2_ready;
	logic             accept;
	logic [PW-1:0]    prod;
	logic [IDX_W-1:0] rem;

	assign s2_ready = !v_s2 || !q_full;
	assign s1_ready = !v_s1 || s2_ready;
	assign full     = !s1_ready;
	assign accept   = push && s1_ready;

	assign prod = PW'(idx_s1) * PW'(RECIP);
	assign rem  = idx_s2 - word_s2 * IDX_W'(WORD_BITS);

	assign q_push = v_s2;
	assign q_din  = {op_s2, rng_s2, ADDR_W'(word_s2), BIT_W'(rem)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			op_s1   <= '0;
			op_s2   <= '0;
			rng_s1  <= 1'b0;
			rng_s2  <= 1'b0;
			idx_s1  <= '0;
			idx_s2  <= '0;
			word_s2 <= '0;
		end else begin
			if (s1_ready) begin
				v_s1 <= push;
			end
			if (accept) begin
				op_s1  <= req.op;
				idx_s1 <= req.block_index;
				rng_s1 <= CW'(req.block_index) < count;
			end
			if (s2_ready) begin
				v_s2 <= v_s1;
			end
			if (s2_ready && v_s1) begin
				op_s2   <= op_s1;
				rng_s2  <= rng_s1;
				idx_s2  <= idx_s1;
				word_s2 <= prod[SH +: IDX_W];
			end
		end
	end

endmodule

@@ src/bba_queue.sv @@
// -----------------------------------------------------------------------------
// bba_queue
// Small register FIFO between the front and the back.
// -----------------------------------------------------------------------------
module bba_queue import bba_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = FIFO_DEPTH,
	localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [WIDTH-1:0] din,
	input  logic             pop,
	output logic             empty,
	output logic [WIDTH-1:0] dout
);

	logic [WIDTH-1:0] ent_q [DEPTH];
	logic [PW-1:0]    wr_q, rd_q;
	logic [PW:0]      cnt_q;
	logic             do_push, do_pop;

	assign full    = cnt_q == (PW+1)'(DEPTH);
	assign empty   = cnt_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = ent_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				ent_q[wr_q] <= din;
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

@@ src/bba_back.sv @@
// -----------------------------------------------------------------------------
// bba_back
// Executes requests on the occupancy map: clear pass after reset, first-fit
// scan for allocate, read-modify-write for free, read for query.
// -----------------------------------------------------------------------------
module bba_back import bba_pkg::*; #(
	parameter int MAX_BLOCKS = DEF_MAX_BLOCKS,
	parameter int WORD_BITS  = DEF_WORD_BITS,
	localparam int CW        = cnt_w(MAX_BLOCKS),
	localparam int MAP_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS,
	localparam int ADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1,
	localparam int BIT_W     = $clog2(WORD_BITS),
	localparam int ENT_W     = OP_W + 1 + ADDR_W + BIT_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [CW-1:0]    count,
	input  logic             q_valid,
	input  logic [ENT_W-1:0] q_dout,
	output logic             q_pop,
	output logic             clearing,
	output logic             empty,
	input  logic             pop,
	output rsp_t             rsp
);

	localparam int BW0 = $clog2(MAX_BLOCKS + WORD_BITS);
	localparam int BW  = (BW0 > CW) ? BW0 : CW;

	typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_SCAN, S_READ} state_t;

	state_t           state_q;
	logic [ADDR_W-1:0] clr_q;
	logic [OP_W-1:0]  cur_op_q;
	logic [ADDR_W-1:0] cur_word_q;
	logic [BIT_W-1:0] cur_bit_q;
	logic [ADDR_W-1:0] iss_q, chk_addr_q;
	logic [BW-1:0]    iss_base_q, chk_base_q;
	logic             chk_vld_q;
	logic             out_vld_q;
	rsp_t             out_q;

	logic [OP_W-1:0]      h_op;
	logic                 h_rng;
	logic [ADDR_W-1:0]    h_word;
	logic [BIT_W-1:0]     h_bit;
	logic                 start;
	logic                 issue;
	logic                 found;
	logic [BW-1:0]        lim;
	logic [WORD_BITS-1:0] mask, free_bits, lowbit, rdata;
	logic [BIT_W-1:0]     pos;
	logic                 we, re;
	logic [ADDR_W-1:0]    waddr, raddr;
	logic [WORD_BITS-1:0] wdata;

	assign h_op   = q_dout[ENT_W-1 -: OP_W];
	assign h_rng  = q_dout[ADDR_W + BIT_W];
	assign h_word = q_dout[BIT_W +: ADDR_W];
	assign h_bit  = q_dout[BIT_W-1:0];

	assign start = (state_q == S_IDLE) && q_valid && !out_vld_q;
	assign q_pop = start;
	assign issue = iss_base_q < BW'(count);
	assign lim   = BW'(count) - chk_base_q;

	// eligible free bits of the word under check, lowest one wins
	always_comb begin
		for (int b = 0; b < WORD_BITS; b++) begin
			mask[b] = BW'(b) < lim;
		end
		free_bits = ~rdata & mask;
		lowbit    = free_bits & (~free_bits + 1'b1);
		pos       = '0;
		for (int b = 0; b < WORD_BITS; b++) begin
			if (lowbit[b]) begin
				pos = pos | BIT_W'(b);
			end
		end
	end

	assign found = chk_vld_q && (free_bits != '0);

	always_comb begin
		we    = 1'b0;
		waddr = clr_q;
		wdata = '0;
		re    = 1'b0;
		raddr = iss_q;
		unique case (state_q)
			S_CLEAR: begin
				we = 1'b1;
			end
			S_IDLE: begin
				if (start && h_rng && (h_op == OP_FREE || h_op == OP_QUERY)) begin
					re    = 1'b1;
					raddr = h_word;
				end
			end
			S_SCAN: begin
				if (found) begin
					we    = 1'b1;
					waddr = chk_addr_q;
					wdata = rdata | lowbit;
				end else if (issue) begin
					re = 1'b1;
				end
			end
			S_READ: begin
				if (cur_op_q == OP_FREE) begin
					we    = 1'b1;
					waddr = cur_word_q;
					wdata = rdata & ~(WORD_BITS'(1) << cur_bit_q);
				end
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	bba_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (MAP_WORDS)
	) u_map (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_q      <= '0;
			cur_op_q   <= '0;
			cur_word_q <= '0;
			cur_bit_q  <= '0;
			iss_q      <= '0;
			iss_base_q <= '0;
			chk_addr_q <= '0;
			chk_base_q <= '0;
			chk_vld_q  <= 1'b0;
			out_vld_q  <= 1'b0;
			out_q      <= '0;
		end else begin
			if (pop && out_vld_q) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ADDR_W'(MAP_WORDS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						cur_op_q   <= h_op;
						cur_word_q <= h_word;
						cur_bit_q  <= h_bit;
						unique case (h_op) inside
							OP_ALLOC: begin
								iss_q      <= '0;
								iss_base_q <= '0;
								chk_vld_q  <= 1'b0;
								state_q    <= S_SCAN;
							end
							OP_FREE, OP_QUERY: begin
								if (h_rng) begin
									state_q <= S_READ;
								end else begin
									out_vld_q <= 1'b1;
									out_q     <= '{status: ST_RANGE, granted_index: '0,
										occupied: 1'b0};
								end
							end
							default: begin
								// unused op: no effect, plain ok
								out_vld_q <= 1'b1;
								out_q     <= '{status: ST_OK, granted_index: '0, occupied: 1'b0};
							end
						endcase
					end
				end
				S_SCAN: begin
					if (found) begin
						out_vld_q <= 1'b1;
						out_q     <= '{status: ST_OK,
							granted_index: IDX_W'(chk_base_q + BW'(pos)), occupied: 1'b0};
						state_q   <= S_IDLE;
					end else if (!issue) begin
						out_vld_q <= 1'b1;
						out_q     <= '{status: ST_FULL, granted_index: '0, occupied: 1'b0};
						state_q   <= S_IDLE;
					end else begin
						// read data of this word arrives next cycle
						chk_vld_q  <= 1'b1;
						chk_addr_q <= iss_q;
						chk_base_q <= iss_base_q;
						iss_q      <= iss_q + 1'b1;
						iss_base_q <= iss_base_q + BW'(WORD_BITS);
					end
				end
				S_READ: begin
					out_vld_q <= 1'b1;
					out_q     <= '{status: ST_OK, granted_index: '0,
						occupied: (cur_op_q == OP_QUERY) && rdata[cur_bit_q]};
					state_q   <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign clearing = state_q == S_CLEAR;
	assign empty    = !out_vld_q;
	assign rsp      = out_q;

endmodule

@@ src/bba_checker.sv @@
// -----------------------------------------------------------------------------
// bba_checker
// Port-level checks on the result side of the allocator.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module bba_checker import bba_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic empty,
	input logic pop,
	input rsp_t rsp
);

	// a waiting result stays until popped
	`ASSERT_NEXT(a_rsp_hold, clk, arst_n, !empty && !pop, !empty)
	`ASSERT_NEXT(a_rsp_stable, clk, arst_n, !empty && !pop, $stable(rsp))

	// only a successful allocate carries an index, only a good query a set bit
	`ASSERT_IMPL(a_fail_clean, clk, arst_n, !empty && rsp.status != ST_OK,
		rsp.granted_index == '0 && !rsp.occupied)
	`ASSERT_IMPL(a_occ_no_grant, clk, arst_n, !empty && rsp.occupied,
		rsp.granted_index == '0)

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.empty  (empty),
	.pop    (pop),
	.rsp    (rsp)
);
